FILE: design/timestamped_packet_queue_late_drop_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped packet queue
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_PACKET_QUEUE_LATE_DROP_ASSERT_SVH
`define TIMESTAMPED_PACKET_QUEUE_LATE_DROP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TPQLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TPQLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tpqld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpqld_pkg
// Shared types and constants of the timestamped packet queue.
// ----------------------------------------------------------------------------
package tpqld_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int REF_W       = 16;

  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 320;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam logic signed [20:0] LATE_RESET  = -21'sd30000;
  localparam logic [19:0]        EARLY_RESET = 20'd30000;
  localparam logic [19:0]        SLEEP_RESET = 20'd15000;

  typedef enum logic [1:0] {
    REG_LATE  = 2'd0,
    REG_EARLY = 2'd1,
    REG_SLEEP = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    STAT_ADDED   = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_RETURN  = 3'd2,
    STAT_NONE    = 3'd3,
    STAT_CLEARED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVAL,
    ST_DONE
  } state_e;

  function automatic logic [31:0] sat_inc32(input logic [31:0] x);
    sat_inc32 = (x == MAX32) ? x : x + 32'd1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

FILE: design/timestamped_packet_queue_late_drop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_packet_queue_late_drop
// Jitter queue of packet references with late drop and saturating statistics.
//   Requests enter on s_axis, one result beat per request leaves on m_axis;
//   tuser carries the request kind in and the status out. Add appends to a
//   16-entry ring, get examines the head against the request time, clear
//   empties the ring and zeroes the statistics.
//   Add, clear, unused kinds and a get on an empty queue go from the exec
//   state straight to done. A get on a non-empty queue reads the head in
//   exec and compares it in eval; each late head is discarded and the next
//   is read and compared in turn, until a packet is returned, an early head
//   stops a get without wait, or the discards empty the queue.
//   s_axis_tready is high only while idle. The result sits in an output
//   register, so the next request may be accepted while it waits on a
//   stalled receiver; a later result waits in the done state until the
//   register frees.
//   Reset empties the queue, zeroes the statistics and loads the limits with
//   -30000 / 30000 / 15000 us; the entry store is not cleared. Limits are to
//   be written over the APB port while the block is idle; it does not check this.
// ----------------------------------------------------------------------------
module timestamped_packet_queue_late_drop (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: packet_ref[15:0], arrival_time[47:16], request_time[79:48],
  //        with_wait[80], zero pad[87:81]
  input  logic [tpqld_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: out_packet_ref[15:0], packet_stamp[47:16], sleep_time[78:48],
  //        skipped_now[83:79], skip_total[115:84], wait_total[147:116],
  //        frame_total[179:148], null_total[211:180], wait_sum[259:212],
  //        delay_sum[307:260], queue_level[312:308], zero pad[319:313]
  output logic [tpqld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]                      m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int PW = tpqld_pkg::PTR_W;
  localparam int CW = tpqld_pkg::CNT_W;
  localparam int RW = tpqld_pkg::REF_W;

  // Configuration
  logic signed [20:0] late_q;
  logic [19:0]        early_q, sleep_min_q;
  logic               cfg_we;

  // Control state
  tpqld_pkg::state_e state_q, state_d;
  logic [PW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [31:0]       skip_cnt_q, skip_cnt_d, wait_cnt_q, wait_cnt_d;
  logic [31:0]       frame_cnt_q, frame_cnt_d, null_cnt_q, null_cnt_d;
  logic [47:0]       wait_acc_q, wait_acc_d, delay_acc_q, delay_acc_d;
  logic              out_valid_q, out_valid_d;

  // Request and working registers
  logic [1:0]        req_q, req_d;
  logic [RW-1:0]     in_ref_q, in_ref_d;
  logic [31:0]       arr_q, arr_d, now_q, now_d;
  logic              wait_q, wait_d;
  tpqld_pkg::status_e status_q, status_d;
  logic [RW-1:0]     oref_q, oref_d;
  logic [31:0]       stamp_q, stamp_d;
  logic [30:0]       sleep_q, sleep_d;
  logic [CW-1:0]     skipped_q, skipped_d;

  logic [tpqld_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [2:0]                       out_user_q, out_user_d;

  // Entry store
  logic [RW-1:0] mem_ref_q   [tpqld_pkg::QUEUE_DEPTH];
  logic [31:0]   mem_stamp_q [tpqld_pkg::QUEUE_DEPTH];
  logic [RW-1:0] rd_ref_q;
  logic [31:0]   rd_stamp_q;
  logic          mem_we;

  // Head evaluation and shared accumulator
  logic [31:0]        diff;
  logic signed [32:0] d_s, early_s, late_s, sleep_s;
  logic               is_early, late_hit, sleep_hit;
  logic [31:0]        late_mag;
  logic               acc_sel;
  logic [47:0]        acc_a, acc_b, acc_sum;
  logic [48:0]        acc_raw;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      late_q      <= tpqld_pkg::LATE_RESET;
      early_q     <= tpqld_pkg::EARLY_RESET;
      sleep_min_q <= tpqld_pkg::SLEEP_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        tpqld_pkg::REG_LATE:  late_q      <= pwdata[20:0];
        tpqld_pkg::REG_EARLY: early_q     <= pwdata[19:0];
        tpqld_pkg::REG_SLEEP: sleep_min_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tpqld_pkg::REG_LATE:  prdata = {{11{late_q[20]}}, late_q};
      tpqld_pkg::REG_EARLY: prdata = {12'd0, early_q};
      tpqld_pkg::REG_SLEEP: prdata = {12'd0, sleep_min_q};
      default:              prdata = '0;
    endcase
  end

  // Head compare: signed wrapping difference against the limits
  assign diff      = rd_stamp_q - now_q;
  assign d_s       = {diff[31], diff};
  assign early_s   = {13'd0, early_q};
  assign late_s    = {{12{late_q[20]}}, late_q};
  assign sleep_s   = {13'd0, sleep_min_q};
  assign is_early  = (d_s >= early_s);
  assign late_hit  = !is_early && (d_s <= late_s);
  assign sleep_hit = wait_q && (d_s > sleep_s);
  assign late_mag  = diff[31] ? (32'd0 - diff) : diff;

  // One saturating 48-bit adder serves both sums
  assign acc_sel = late_hit;
  assign acc_a   = acc_sel ? delay_acc_q : wait_acc_q;
  assign acc_b   = acc_sel ? {16'd0, late_mag} : {17'd0, diff[30:0]};
  assign acc_raw = {1'b0, acc_a} + {1'b0, acc_b};
  assign acc_sum = (acc_raw > {1'b0, tpqld_pkg::MAX48}) ? tpqld_pkg::MAX48 : acc_raw[47:0];

  assign s_axis_tready = (state_q == tpqld_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    skip_cnt_d  = skip_cnt_q;
    wait_cnt_d  = wait_cnt_q;
    frame_cnt_d = frame_cnt_q;
    null_cnt_d  = null_cnt_q;
    wait_acc_d  = wait_acc_q;
    delay_acc_d = delay_acc_q;
    req_d       = req_q;
    in_ref_d    = in_ref_q;
    arr_d       = arr_q;
    now_d       = now_q;
    wait_d      = wait_q;
    status_d    = status_q;
    oref_d      = oref_q;
    stamp_d     = stamp_q;
    sleep_d     = sleep_q;
    skipped_d   = skipped_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;

    case (state_q)
      tpqld_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d     = s_axis_tuser;
          in_ref_d  = s_axis_tdata[15:0];
          arr_d     = s_axis_tdata[47:16];
          now_d     = s_axis_tdata[79:48];
          wait_d    = s_axis_tdata[80];
          status_d  = tpqld_pkg::STAT_NONE;
          oref_d    = '0;
          stamp_d   = '0;
          sleep_d   = '0;
          skipped_d = '0;
          state_d   = tpqld_pkg::ST_EXEC;
        end
      end

      tpqld_pkg::ST_EXEC: begin
        state_d = tpqld_pkg::ST_DONE;
        case (req_q)
          tpqld_pkg::REQ_ADD: begin
            if (fill_q == CW'(tpqld_pkg::QUEUE_DEPTH)) begin
              status_d = tpqld_pkg::STAT_FULL;
            end else begin
              mem_we   = 1'b1;
              tail_d   = tpqld_pkg::ptr_next(tail_q);
              fill_d   = fill_q + CW'(1);
              status_d = tpqld_pkg::STAT_ADDED;
            end
          end
          tpqld_pkg::REQ_GET: begin
            if (fill_q == '0) begin
              null_cnt_d = tpqld_pkg::sat_inc32(null_cnt_q);
              status_d   = tpqld_pkg::STAT_NONE;
            end else begin
              // head entry is read this cycle, evaluated next
              state_d = tpqld_pkg::ST_EVAL;
            end
          end
          tpqld_pkg::REQ_CLEAR: begin
            head_d      = '0;
            tail_d      = '0;
            fill_d      = '0;
            skip_cnt_d  = '0;
            wait_cnt_d  = '0;
            frame_cnt_d = '0;
            null_cnt_d  = '0;
            wait_acc_d  = '0;
            delay_acc_d = '0;
            status_d    = tpqld_pkg::STAT_CLEARED;
          end
          default: status_d = tpqld_pkg::STAT_NONE;
        endcase
      end

      tpqld_pkg::ST_EVAL: begin
        stamp_d = rd_stamp_q;
        if (is_early && !wait_q) begin
          null_cnt_d = tpqld_pkg::sat_inc32(null_cnt_q);
          status_d   = tpqld_pkg::STAT_NONE;
          state_d    = tpqld_pkg::ST_DONE;
        end else if (late_hit) begin
          // discard and go look at the next head
          head_d      = tpqld_pkg::ptr_next(head_q);
          fill_d      = fill_q - CW'(1);
          skipped_d   = skipped_q + CW'(1);
          skip_cnt_d  = tpqld_pkg::sat_inc32(skip_cnt_q);
          delay_acc_d = acc_sum;
          state_d     = tpqld_pkg::ST_EXEC;
        end else begin
          if (sleep_hit) begin
            sleep_d    = diff[30:0];
            wait_acc_d = acc_sum;
            wait_cnt_d = tpqld_pkg::sat_inc32(wait_cnt_q);
          end
          frame_cnt_d = tpqld_pkg::sat_inc32(frame_cnt_q);
          oref_d      = rd_ref_q;
          head_d      = tpqld_pkg::ptr_next(head_q);
          fill_d      = fill_q - CW'(1);
          status_d    = tpqld_pkg::STAT_RETURN;
          state_d     = tpqld_pkg::ST_DONE;
        end
      end

      tpqld_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {7'd0, 5'(fill_q), delay_acc_q, wait_acc_q, null_cnt_q,
                         frame_cnt_q, wait_cnt_q, skip_cnt_q, 5'(skipped_q),
                         sleep_q, stamp_q, 16'(oref_q)};
          out_user_d  = status_q;
          out_valid_d = 1'b1;
          state_d     = tpqld_pkg::ST_IDLE;
        end
      end

      default: state_d = tpqld_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpqld_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      skip_cnt_q  <= '0;
      wait_cnt_q  <= '0;
      frame_cnt_q <= '0;
      null_cnt_q  <= '0;
      wait_acc_q  <= '0;
      delay_acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      skip_cnt_q  <= skip_cnt_d;
      wait_cnt_q  <= wait_cnt_d;
      frame_cnt_q <= frame_cnt_d;
      null_cnt_q  <= null_cnt_d;
      wait_acc_q  <= wait_acc_d;
      delay_acc_q <= delay_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    in_ref_q   <= in_ref_d;
    arr_q      <= arr_d;
    now_q      <= now_d;
    wait_q     <= wait_d;
    status_q   <= status_d;
    oref_q     <= oref_d;
    stamp_q    <= stamp_d;
    sleep_q    <= sleep_d;
    skipped_q  <= skipped_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // Entry store: written at the tail, head read registered every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_ref_q[tail_q]   <= in_ref_q;
      mem_stamp_q[tail_q] <= arr_q;
    end
    rd_ref_q   <= mem_ref_q[head_q];
    rd_stamp_q <= mem_stamp_q[head_q];
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tvalid = out_valid_q;

endmodule

FILE: design/tpqld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpqld_checker
// Port-level checks of the timestamped packet queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "timestamped_packet_queue_late_drop_assert.svh"

module tpqld_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [tpqld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [2:0]                       m_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);

  logic m_stall;
  logic is_return, is_cleared, is_added;

  assign m_stall    = m_axis_tvalid && !m_axis_tready;
  assign is_return  = (m_axis_tuser == tpqld_pkg::STAT_RETURN);
  assign is_cleared = (m_axis_tuser == tpqld_pkg::STAT_CLEARED);
  assign is_added   = (m_axis_tuser == tpqld_pkg::STAT_ADDED);

  // a stalled result beat must not change
  `TPQLD_ASSERT_NEXT(a_out_hold, m_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // one request in flight: busy right after a beat is taken
  `TPQLD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

  // only a returned packet can carry a sleep
  `TPQLD_ASSERT_NOW(a_sleep_only_on_return, m_axis_tvalid && (m_axis_tdata[78:48] != '0), is_return, "sleep without returned packet")

  // clear leaves empty queue and zero statistics
  `TPQLD_ASSERT_NOW(a_clear_zeroes, m_axis_tvalid && is_cleared, m_axis_tdata[312:84] == '0, "clear left state behind")

  // an add never discards and always leaves at least one entry
  `TPQLD_ASSERT_NOW(a_add_level, m_axis_tvalid && is_added, (m_axis_tdata[83:79] == '0) && (m_axis_tdata[312:308] != '0), "add result inconsistent")

endmodule

bind timestamped_packet_queue_late_drop tpqld_checker u_tpqld_checker (.*);
